// File: design/sxf_pkg.sv
// ----------------------------------------------------------------------------
// sxf_pkg: shared definitions of the Sobel-x RGB filter
// Pixel and sum widths, register defaults, register indexes and the
// configuration bundle passed from the register block to the front end.
// ----------------------------------------------------------------------------
package sxf_pkg;

   localparam int PIX_W          = 8;
   localparam int NUM_CH         = 3;
   localparam int RGB_W          = PIX_W * NUM_CH;
   // top + 2*mid + bottom of three 8-bit values
   localparam int SUM_W          = PIX_W + 2;
   localparam int CLAMP_MAX      = 255;

   localparam int WIDTH_REG_W    = 11;
   localparam int HEIGHT_REG_W   = 16;
   localparam int ROW_W          = HEIGHT_REG_W;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int FIFO_DEPTH_DEF = 4;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

   // smallest frame side the window logic supports
   localparam int MIN_SIDE       = 3;

   // register index, taken from the word address
   localparam logic REG_WIDTH    = 1'b0;
   localparam logic REG_HEIGHT   = 1'b1;

   typedef logic [SUM_W-1:0] vsum_type;
   typedef vsum_type [NUM_CH-1:0] vsum3_type;

   typedef struct packed {
      logic [WIDTH_REG_W-1:0]  image_width;
      logic [HEIGHT_REG_W-1:0] image_height;
      logic                    restart;
   } cfg_type;

endpackage

// File: design/sobel_x_rgb_filter.sv
// ----------------------------------------------------------------------------
// sobel_x_rgb_filter: Sobel-x gradient on an RGB raster pixel stream
// Pixels enter on the req_ channel in raster order, one per transfer. For
// every interior pixel one clamped gradient leaves on the rsp_ channel, in
// raster order; rsp_frame_end marks the last interior pixel of a frame.
// Border rows and columns give no transfer on rsp_.
// A result passes the queue, the datapath stage and the output register
// after the pixel that completes its window (below-right of center) arrives.
// Throughput is one pixel per cycle unless the receiver stalls; it is set
// by the single read and write port of each line store, used once per pixel.
// A four-entry queue decouples intake from the datapath; req_ready drops
// only when that queue is full, so a stalled receiver backs up the output
// register, then the datapath stage, then the queue, and then req_.
// Width and height are set through the APB port (width at 0x0, height at
// 0x4); any write restarts the frame at row 0, column 0 and must be done
// while the block is idle. Reset loads 640 x 480 and empties the pipeline.
// Line store contents are undefined after reset and need no clearing pass.
// ----------------------------------------------------------------------------
module sobel_x_rgb_filter #(
   parameter int MAX_WIDTH  = sxf_pkg::MAX_WIDTH_DEF,
   parameter int FIFO_DEPTH = sxf_pkg::FIFO_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [sxf_pkg::PIX_W-1:0] req_red_in,
   input  logic [sxf_pkg::PIX_W-1:0] req_green_in,
   input  logic [sxf_pkg::PIX_W-1:0] req_blue_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [sxf_pkg::PIX_W-1:0] rsp_red_out,
   output logic [sxf_pkg::PIX_W-1:0] rsp_green_out,
   output logic [sxf_pkg::PIX_W-1:0] rsp_blue_out,
   output logic                      rsp_frame_end,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int ENTRY_W = sxf_pkg::RGB_W + CW + 2;

   logic [sxf_pkg::WIDTH_REG_W-1:0]  width_ff;
   logic [sxf_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic                             csr_write;
   sxf_pkg::cfg_type                 cfg;

   logic                             push_valid, push_ready;
   logic [ENTRY_W-1:0]               push_data;
   logic                             fifo_valid, fifo_pop;
   logic [ENTRY_W-1:0]               fifo_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sxf_pkg::WIDTH_RESET;
         height_ff <= sxf_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            sxf_pkg::REG_WIDTH:  width_ff  <= pwdata[sxf_pkg::WIDTH_REG_W-1:0];
            sxf_pkg::REG_HEIGHT: height_ff <= pwdata[sxf_pkg::HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         sxf_pkg::REG_WIDTH:  prdata = {21'd0, width_ff};
         sxf_pkg::REG_HEIGHT: prdata = {16'd0, height_ff};
         default:             prdata = '0;
      endcase
   end

   assign cfg.image_width  = width_ff;
   assign cfg.image_height = height_ff;
   assign cfg.restart      = csr_write;

   sxf_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .CW        (CW),
      .ENTRY_W   (ENTRY_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   sxf_fifo #(
      .DATA_W (ENTRY_W),
      .DEPTH  (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (fifo_valid),
      .pop_ready  (fifo_pop),
      .pop_data   (fifo_data)
   );

   sxf_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .CW        (CW),
      .ENTRY_W   (ENTRY_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (fifo_valid),
      .pop_ready     (fifo_pop),
      .pop_data      (fifo_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

   // an accepted pixel is queued for the datapath on the next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> fifo_valid)
      else $error("accepted pixel missing from queue");

   // the datapath never takes an item from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> fifo_valid)
      else $error("pop from empty queue");

   // a pixel transfer into a full queue would be lost
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> push_ready)
      else $error("pixel accepted while queue full");

endmodule

// File: design/sxf_fifo.sv
// ----------------------------------------------------------------------------
// sxf_fifo: small queue between front end and back end
// Register-based first-in first-out buffer with a fill count.
// ----------------------------------------------------------------------------
module sxf_fifo #(
   parameter int DATA_W = 36,
   parameter int DEPTH  = sxf_pkg::FIFO_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNTW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/sxf_front.sv
// ----------------------------------------------------------------------------
// sxf_front: pixel intake and position tracking
// Accepts pixels, tracks column and row, tags each pixel with whether it
// completes an interior window and whether that window ends the frame.
// ----------------------------------------------------------------------------
module sxf_front #(
   parameter int MAX_WIDTH = sxf_pkg::MAX_WIDTH_DEF,
   parameter int CW        = $clog2(MAX_WIDTH),
   parameter int ENTRY_W   = sxf_pkg::RGB_W + CW + 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sxf_pkg::cfg_type                  cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sxf_pkg::PIX_W-1:0]         req_red_in,
   input  logic [sxf_pkg::PIX_W-1:0]         req_green_in,
   input  logic [sxf_pkg::PIX_W-1:0]         req_blue_in,
   output logic                              push_valid,
   input  logic                              push_ready,
   output logic [ENTRY_W-1:0]                push_data
);

   logic [CW-1:0]             col_ff, col_in;
   logic [sxf_pkg::ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0]             col_last;
   logic [sxf_pkg::ROW_W-1:0] row_last;
   logic                      accept;
   logic                      emit;
   logic                      frame_end;

   // effective last column and row after clamping the registers
   always_comb begin
      if (int'(cfg.image_width) < sxf_pkg::MIN_SIDE) begin
         col_last = CW'(sxf_pkg::MIN_SIDE - 1);
      end else if (int'(cfg.image_width) > MAX_WIDTH) begin
         col_last = CW'(MAX_WIDTH - 1);
      end else begin
         col_last = CW'(cfg.image_width - 11'd1);
      end
      if (int'(cfg.image_height) < sxf_pkg::MIN_SIDE) begin
         row_last = sxf_pkg::ROW_W'(sxf_pkg::MIN_SIDE - 1);
      end else begin
         row_last = cfg.image_height - 16'd1;
      end
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   assign emit      = (row_ff >= sxf_pkg::ROW_W'(2)) && (col_ff >= CW'(2));
   assign frame_end = (row_ff == row_last) && (col_ff == col_last);
   assign push_data = {frame_end, emit, col_ff, req_blue_in, req_green_in, req_red_in};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == col_last) begin
            col_in = '0;
            row_in = (row_ff == row_last) ? '0 : row_ff + sxf_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: design/sxf_back.sv
// ----------------------------------------------------------------------------
// sxf_back: line stores, window and gradient datapath
// Reads both line stores for a queued pixel, forms the vertical weighted
// column sums, subtracts across the window and clamps into the output register.
// ----------------------------------------------------------------------------
module sxf_back #(
   parameter int MAX_WIDTH = sxf_pkg::MAX_WIDTH_DEF,
   parameter int CW        = $clog2(MAX_WIDTH),
   parameter int ENTRY_W   = sxf_pkg::RGB_W + CW + 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  logic [ENTRY_W-1:0]        pop_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [sxf_pkg::PIX_W-1:0] rsp_red_out,
   output logic [sxf_pkg::PIX_W-1:0] rsp_green_out,
   output logic [sxf_pkg::PIX_W-1:0] rsp_blue_out,
   output logic                      rsp_frame_end
);

   localparam int PW = sxf_pkg::PIX_W;
   localparam int SW = sxf_pkg::SUM_W;

   logic [sxf_pkg::RGB_W-1:0] upper_mem  [MAX_WIDTH];
   logic [sxf_pkg::RGB_W-1:0] middle_mem [MAX_WIDTH];

   logic [CW-1:0]             pop_col;
   logic                      pop;

   logic                      s1_valid_ff, s1_valid_in;
   logic [sxf_pkg::RGB_W-1:0] s1_px_ff;
   logic [CW-1:0]             s1_col_ff;
   logic                      s1_emit_ff;
   logic                      s1_fe_ff;
   logic [sxf_pkg::RGB_W-1:0] top_rd_ff;
   logic [sxf_pkg::RGB_W-1:0] mid_rd_ff;
   logic                      s1_adv;

   sxf_pkg::vsum3_type        win0_ff, win1_ff;
   sxf_pkg::vsum3_type        cur;
   logic [sxf_pkg::RGB_W-1:0] grad;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [sxf_pkg::RGB_W-1:0] rsp_rgb_ff;
   logic                      rsp_fe_ff;

   assign pop_col = pop_data[sxf_pkg::RGB_W +: CW];

   // an item without a result never waits for the output register
   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_ready);
   assign pop       = pop_valid && (!s1_valid_ff || s1_adv);
   assign pop_ready = pop;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // vertical sums and clamped horizontal difference per channel
   always_comb begin
      for (int k = 0; k < sxf_pkg::NUM_CH; k++) begin
         cur[k] = {2'b00, top_rd_ff[PW*k +: PW]}
                + {1'b0, mid_rd_ff[PW*k +: PW], 1'b0}
                + {2'b00, s1_px_ff[PW*k +: PW]};
         if (cur[k] >= win1_ff[k]) begin
            grad[PW*k +: PW] = '0;
         end else if ((win1_ff[k] - cur[k]) > SW'(sxf_pkg::CLAMP_MAX)) begin
            grad[PW*k +: PW] = PW'(sxf_pkg::CLAMP_MAX);
         end else begin
            grad[PW*k +: PW] = PW'(win1_ff[k] - cur[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win0_ff      <= '0;
         win1_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            win1_ff <= win0_ff;
            win0_ff <= cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_px_ff   <= pop_data[sxf_pkg::RGB_W-1:0];
         s1_col_ff  <= pop_col;
         s1_emit_ff <= pop_data[sxf_pkg::RGB_W + CW];
         s1_fe_ff   <= pop_data[sxf_pkg::RGB_W + CW + 1];
      end
      if (s1_adv && s1_emit_ff) begin
         rsp_rgb_ff <= grad;
         rsp_fe_ff  <= s1_fe_ff;
      end
   end

   // line store reads; consecutive pixels never share a column
   always_ff @(posedge clock) begin
      if (pop) begin
         top_rd_ff <= upper_mem[pop_col];
         mid_rd_ff <= middle_mem[pop_col];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         upper_mem[s1_col_ff]  <= mid_rd_ff;
         middle_mem[s1_col_ff] <= s1_px_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_rgb_ff[0*PW +: PW];
   assign rsp_green_out = rsp_rgb_ff[1*PW +: PW];
   assign rsp_blue_out  = rsp_rgb_ff[2*PW +: PW];
   assign rsp_frame_end = rsp_fe_ff;

endmodule
